// ===== hw/rtl/hdfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_pkg
// Shared types and codes for the half-duplex frame buffer.
// ----------------------------------------------------------------------------
package hdfb_pkg;

  // request codes
  localparam logic [2:0] REQ_RX_BYTE   = 3'd0;
  localparam logic [2:0] REQ_BUF_READ  = 3'd1;
  localparam logic [2:0] REQ_BUF_WRITE = 3'd2;
  localparam logic [2:0] REQ_REPLY     = 3'd3;
  localparam logic [2:0] REQ_TX_SLOT   = 3'd4;
  localparam logic [2:0] REQ_TX_DONE   = 3'd5;

  // link modes
  localparam logic [2:0] MODE_LISTEN = 3'd0;
  localparam logic [2:0] MODE_RECV   = 3'd1;
  localparam logic [2:0] MODE_HOLD   = 3'd2;
  localparam logic [2:0] MODE_SEND   = 3'd3;
  localparam logic [2:0] MODE_DRAIN  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_MARKER  = 2'd0;
  localparam logic [1:0] CFG_LENGTH_INDEX  = 2'd1;
  localparam logic [1:0] CFG_TRAILER_BYTES = 2'd2;

  typedef struct packed {
    logic [7:0] frame_marker;
    logic [6:0] length_index;
    logic [7:0] trailer_bytes;
  } hdfb_cfg_t;

  // buffer access for one transaction; addresses are trimmed by the user
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } hdfb_mem_req_t;

  // result of one transaction, before the buffer read data is merged in
  typedef struct packed {
    logic       tx_valid;
    logic       tx_from_ram;
    logic [7:0] tx_const;
    logic       tx_enable;
    logic       frame_ready;
    logic [7:0] frame_length;
    logic       rd_from_ram;
    logic       overflow;
    logic [2:0] mode;
  } hdfb_res_t;

endpackage

// ===== hw/rtl/hdfb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hdfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hdfb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_ctrl
// Link state machine: deframing counters, reply sequencing, buffer requests.
// ----------------------------------------------------------------------------
module hdfb_ctrl #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  hdfb_pkg::hdfb_cfg_t    cfg,
  input  logic [2:0]             req_type,
  input  logic [7:0]             data_byte,
  input  logic [6:0]             address,
  input  logic [7:0]             response_size,
  output hdfb_pkg::hdfb_res_t    res,
  output hdfb_pkg::hdfb_mem_req_t mem
);
  import hdfb_pkg::*;

  localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

  logic [2:0] link_mode,       link_mode_next;
  logic [7:0] fill_count,      fill_count_next;
  logic [8:0] bytes_remaining, bytes_remaining_next;
  logic [7:0] send_pointer,    send_pointer_next;

  logic [7:0] addr_ext;
  logic [7:0] len_pos;
  logic [8:0] len_sum;
  logic [7:0] reply_len;

  assign addr_ext  = {1'b0, address};
  assign len_pos   = {1'b0, cfg.length_index};
  assign len_sum   = {1'b0, data_byte} + {1'b0, cfg.trailer_bytes};
  assign reply_len = (response_size > DEPTH_B) ? DEPTH_B : response_size;

  always_comb begin
    link_mode_next       = link_mode;
    fill_count_next      = fill_count;
    bytes_remaining_next = bytes_remaining;
    send_pointer_next    = send_pointer;
    res                  = '0;
    mem                  = '0;

    case (req_type)
      REQ_RX_BYTE: begin
        if (link_mode == MODE_LISTEN) begin
          if (data_byte == cfg.frame_marker) begin
            link_mode_next  = MODE_RECV;
            fill_count_next = 8'd0;
          end
        end else if (link_mode == MODE_RECV) begin
          if (fill_count >= DEPTH_B) begin
            // no room: drop the frame
            res.overflow    = 1'b1;
            link_mode_next  = MODE_LISTEN;
            fill_count_next = 8'd0;
          end else begin
            mem.we          = 1'b1;
            mem.waddr       = fill_count;
            mem.wdata       = data_byte;
            fill_count_next = fill_count + 8'd1;
            if (fill_count == len_pos) begin
              bytes_remaining_next = len_sum;
              if (len_sum == 9'd0) begin
                link_mode_next  = MODE_HOLD;
                res.frame_ready = 1'b1;
              end
            end else if (fill_count > len_pos) begin
              if (bytes_remaining <= 9'd1) begin
                bytes_remaining_next = 9'd0;
                link_mode_next       = MODE_HOLD;
                res.frame_ready      = 1'b1;
              end else begin
                bytes_remaining_next = bytes_remaining - 9'd1;
              end
            end
          end
        end
      end
      REQ_BUF_READ: begin
        if (addr_ext < DEPTH_B) begin
          mem.re          = 1'b1;
          mem.raddr       = addr_ext;
          res.rd_from_ram = 1'b1;
        end
      end
      REQ_BUF_WRITE: begin
        if (addr_ext < DEPTH_B) begin
          mem.we    = 1'b1;
          mem.waddr = addr_ext;
          mem.wdata = data_byte;
        end
      end
      REQ_REPLY: begin
        if (link_mode == MODE_HOLD) begin
          if (reply_len == 8'd0) begin
            link_mode_next  = MODE_LISTEN;
            fill_count_next = 8'd0;
          end else begin
            bytes_remaining_next = {1'b0, reply_len};
            send_pointer_next    = 8'd0;
            link_mode_next       = MODE_SEND;
            res.tx_valid         = 1'b1;
            res.tx_const         = cfg.frame_marker;
          end
        end
      end
      REQ_TX_SLOT: begin
        if ((link_mode == MODE_SEND) && (bytes_remaining != 9'd0)) begin
          res.tx_valid = 1'b1;
          if (send_pointer < DEPTH_B) begin
            mem.re          = 1'b1;
            mem.raddr       = send_pointer;
            res.tx_from_ram = 1'b1;
          end
          send_pointer_next    = send_pointer + 8'd1;
          bytes_remaining_next = bytes_remaining - 9'd1;
          if (bytes_remaining == 9'd1) begin
            link_mode_next = MODE_DRAIN;
          end
        end
      end
      REQ_TX_DONE: begin
        if (link_mode == MODE_DRAIN) begin
          link_mode_next  = MODE_LISTEN;
          fill_count_next = 8'd0;
        end
      end
      default: begin
      end
    endcase

    res.mode         = link_mode_next;
    res.tx_enable    = (link_mode_next == MODE_SEND) || (link_mode_next == MODE_DRAIN);
    res.frame_length = fill_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_mode       <= MODE_LISTEN;
      fill_count      <= 8'd0;
      bytes_remaining <= 9'd0;
      send_pointer    <= 8'd0;
    end else if (accept) begin
      link_mode       <= link_mode_next;
      fill_count      <= fill_count_next;
      bytes_remaining <= bytes_remaining_next;
      send_pointer    <= send_pointer_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= DEPTH_B)
    else $error("fill_count beyond buffer depth");

  a_send_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (link_mode == MODE_SEND) |-> (bytes_remaining != 9'd0))
    else $error("sending with nothing left to send");

  a_rx_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (accept && mem.we && (req_type == REQ_RX_BYTE)) |-> (fill_count < DEPTH_B))
    else $error("receive write past end of buffer");
`endif

endmodule

// ===== hw/rtl/half_duplex_frame_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_frame_buffer_unit
// Sentinel/length deframer and reply sender around one shared frame buffer.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  req     | req_valid / req_stall | req_type, data_byte, address,
//          |                       | response_size
//  rsp     | rsp_valid / rsp_stall | tx_valid, tx_byte, tx_enable, frame_ready,
//          |                       | frame_length, read_data, overflow, mode
//  cfg     | cfg_write             | cfg_index, cfg_data
//
//  One transaction per clock sustained while the response side does not stall;
//  a taken request passes the state update + buffer access stage (s1), then
//  the output register, which picks up the buffer's registered read data.
//  rst (synchronous) returns the link to listening with counters cleared; the
//  buffer contents are not cleared and need no clearing pass.
//  A stalled response holds; req_stall rises only when the stage behind the
//  state machine is full and the output register cannot drain.
//
module half_duplex_frame_buffer_unit #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // request channel
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [2:0] req_type,
  input  logic [7:0] data_byte,
  input  logic [6:0] address,
  input  logic [7:0] response_size,
  // response channel
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       tx_enable,
  output logic       frame_ready,
  output logic [7:0] frame_length,
  output logic [7:0] read_data,
  output logic       overflow,
  output logic [2:0] mode
);
  import hdfb_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  // configuration registers
  hdfb_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_marker  <= 8'd0;
      cfg.length_index  <= 7'd1;
      cfg.trailer_bytes <= 8'd5;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_MARKER:  cfg.frame_marker  <= cfg_data;
        CFG_LENGTH_INDEX:  cfg.length_index  <= cfg_data[6:0];
        CFG_TRAILER_BYTES: cfg.trailer_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline: accept -> s1 (buffer read in flight) -> rsp output register.
  logic          accept;
  logic          out_free;
  logic          s1_move;
  logic          s1_valid;
  hdfb_res_t     s1_res;
  hdfb_res_t     res;
  hdfb_mem_req_t mem;
  logic [7:0]    ram_rdata;

  hdfb_res_t     rsp_res;
  logic [7:0]    rsp_tx_byte;
  logic [7:0]    rsp_read_data;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_move   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;
  assign accept    = req_valid && !req_stall;

  hdfb_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cfg          (cfg),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .address      (address),
    .response_size(response_size),
    .res          (res),
    .mem          (mem)
  );

  // read data stays put while s1 waits, since no new read is issued then
  hdfb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem.we && accept),
    .waddr(mem.waddr[AW-1:0]),
    .wdata(mem.wdata),
    .re   (mem.re && accept),
    .raddr(mem.raddr[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !out_free);
      if (out_free) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
    if (s1_move) begin
      rsp_res       <= s1_res;
      rsp_tx_byte   <= s1_res.tx_from_ram ? ram_rdata : s1_res.tx_const;
      rsp_read_data <= s1_res.rd_from_ram ? ram_rdata : 8'd0;
    end
  end

  assign tx_valid     = rsp_res.tx_valid;
  assign tx_byte      = rsp_tx_byte;
  assign tx_enable    = rsp_res.tx_enable;
  assign frame_ready  = rsp_res.frame_ready;
  assign frame_length = rsp_res.frame_length;
  assign read_data    = rsp_read_data;
  assign overflow     = rsp_res.overflow;
  assign mode         = rsp_res.mode;

`ifndef SYNTHESIS
  a_tx_needs_driver: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && tx_valid) |-> tx_enable)
    else $error("byte sent with line driver off");

  a_ready_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && frame_ready) |-> (mode == MODE_HOLD))
    else $error("frame completed without holding it");

  a_overflow_drops: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && overflow) |-> ((mode == MODE_LISTEN) && (frame_length == 8'd0)))
    else $error("overflow did not drop the frame");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && rsp_valid))
    else $error("request stalled with room in the pipeline");
`endif

endmodule

// ===== tb/hdfb_link_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_link_checker
// Watches the request, response and register ports of the frame buffer unit,
// keeps its own copy of the link state and buffer, and compares every
// response, in order, against the predicted one.
// ----------------------------------------------------------------------------
module hdfb_link_checker #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       req_valid,
  input  logic       req_stall,
  input  logic [2:0] req_type,
  input  logic [7:0] data_byte,
  input  logic [6:0] address,
  input  logic [7:0] response_size,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  logic       tx_valid,
  input  logic [7:0] tx_byte,
  input  logic       tx_enable,
  input  logic       frame_ready,
  input  logic [7:0] frame_length,
  input  logic [7:0] read_data,
  input  logic       overflow,
  input  logic [2:0] mode,
  output int         mismatch_count,
  output int         pending,
  output logic [2:0] link_mode_now,
  output logic [7:0] fill_now
);
  import hdfb_pkg::*;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_enable;
    logic       frame_ready;
    logic [7:0] frame_length;
    logic [7:0] read_data;
    logic       overflow;
    logic [2:0] mode;
  } link_rsp_t;

  logic [7:0] sentinel;
  logic [6:0] len_idx;
  logic [7:0] trailer;

  logic [2:0] lmode;
  logic [7:0] fill;
  logic [8:0] remaining;
  logic [7:0] send_ptr;
  logic [7:0] store [BUFFER_DEPTH];

  link_rsp_t link_rsp_q[$];

  assign link_mode_now = lmode;
  assign fill_now      = fill;

  task automatic report(input string msg);
    mismatch_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [8:0] got,
                             input logic [8:0] want);
    if (got !== want) report($sformatf("response %s: got %0h, want %0h", name, got, want));
  endtask

  // one transaction through the deframer / replier
  task automatic link_step(input logic [2:0] op, input logic [7:0] din,
                           input logic [6:0] addr, input logic [7:0] rsize,
                           output link_rsp_t r);
    int unsigned pos;
    int unsigned n;
    r = '0;
    case (op)
      REQ_RX_BYTE: begin
        if (lmode == MODE_LISTEN) begin
          if (din == sentinel) begin
            lmode = MODE_RECV;
            fill  = '0;
          end
        end else if (lmode == MODE_RECV) begin
          if (fill >= BUFFER_DEPTH) begin
            // no room left: drop the frame
            r.overflow = 1'b1;
            lmode      = MODE_LISTEN;
            fill       = '0;
          end else begin
            pos        = fill;
            store[pos] = din;
            fill       = 8'(pos + 1);
            if (pos == len_idx) begin
              remaining = {1'b0, din} + {1'b0, trailer};
              if (remaining == 0) begin
                lmode         = MODE_HOLD;
                r.frame_ready = 1'b1;
              end
            end else if (pos > len_idx) begin
              if (remaining <= 1) begin
                remaining     = '0;
                lmode         = MODE_HOLD;
                r.frame_ready = 1'b1;
              end else begin
                remaining = remaining - 1'b1;
              end
            end
          end
        end
      end
      REQ_BUF_READ: begin
        if (addr < BUFFER_DEPTH) r.read_data = store[addr];
      end
      REQ_BUF_WRITE: begin
        if (addr < BUFFER_DEPTH) store[addr] = din;
      end
      REQ_REPLY: begin
        if (lmode == MODE_HOLD) begin
          n = (rsize > BUFFER_DEPTH) ? BUFFER_DEPTH : rsize;
          if (n == 0) begin
            lmode = MODE_LISTEN;
            fill  = '0;
          end else begin
            remaining  = 9'(n);
            send_ptr   = '0;
            lmode      = MODE_SEND;
            r.tx_valid = 1'b1;
            r.tx_byte  = sentinel;
          end
        end
      end
      REQ_TX_SLOT: begin
        if (lmode == MODE_SEND && remaining > 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = (send_ptr < BUFFER_DEPTH) ? store[send_ptr] : 8'h00;
          send_ptr   = send_ptr + 1'b1;
          remaining  = remaining - 1'b1;
          if (remaining == 0) lmode = MODE_DRAIN;
        end
      end
      REQ_TX_DONE: begin
        if (lmode == MODE_DRAIN) begin
          lmode = MODE_LISTEN;
          fill  = '0;
        end
      end
      default: ;
    endcase
    r.tx_enable    = (lmode == MODE_SEND) || (lmode == MODE_DRAIN);
    r.frame_length = fill;
    r.mode         = lmode;
  endtask

  always @(posedge clk) begin : watch
    link_rsp_t want;
    if (rst) begin
      sentinel  = 8'h00;
      len_idx   = 7'd1;
      trailer   = 8'd5;
      lmode     = MODE_LISTEN;
      fill      = '0;
      remaining = '0;
      send_ptr  = '0;
      link_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (link_rsp_q.size() == 0) begin
          report("response with no request outstanding");
        end else begin
          want = link_rsp_q.pop_front();
          check_field("tx_valid", tx_valid, want.tx_valid);
          check_field("tx_byte", tx_byte, want.tx_byte);
          check_field("tx_enable", tx_enable, want.tx_enable);
          check_field("frame_ready", frame_ready, want.frame_ready);
          check_field("frame_length", frame_length, want.frame_length);
          check_field("read_data", read_data, want.read_data);
          check_field("overflow", overflow, want.overflow);
          check_field("mode", mode, want.mode);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_FRAME_MARKER:  sentinel = cfg_data;
          CFG_LENGTH_INDEX:  len_idx  = cfg_data[6:0];
          CFG_TRAILER_BYTES: trailer  = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        link_step(req_type, data_byte, address, response_size, want);
        link_rsp_q.push_back(want);
      end
    end
    pending = link_rsp_q.size();
  end

endmodule

// ===== tb/tb_half_duplex_frame_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_half_duplex_frame_buffer_unit
// Self-checking bench for the half-duplex frame buffer: fills the buffer,
// runs a short directed walk through every request and mode, then random
// frame/reply sessions under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_half_duplex_frame_buffer_unit;
  import hdfb_pkg::*;

  localparam int BUFFER_DEPTH = 128;
  // request to response: state + buffer stage, then output register
  localparam int LINK_LATENCY = 2;
  // far above the slowest legal run (a few thousand transactions)
  localparam int CYCLE_LIMIT  = 200000;

  // request codes the block defines no action for
  localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       req_valid;
  logic       req_stall;
  logic [2:0] req_type;
  logic [7:0] data_byte;
  logic [6:0] address;
  logic [7:0] response_size;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_enable;
  logic       frame_ready;
  logic [7:0] frame_length;
  logic [7:0] read_data;
  logic       overflow;
  logic [2:0] mode;

  // from the checker
  int         mismatches;
  int         pending;
  logic [2:0] pred_mode;
  logic [7:0] pred_fill;

  // register values as last written, used to shape frames
  logic [7:0] sentinel;
  logic [6:0] len_idx;
  logic [7:0] trailer;

  int idle_pct;
  int stall_pct;
  int cycles = 0;

  half_duplex_frame_buffer_unit #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .address      (address),
    .response_size(response_size),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .tx_enable    (tx_enable),
    .frame_ready  (frame_ready),
    .frame_length (frame_length),
    .read_data    (read_data),
    .overflow     (overflow),
    .mode         (mode)
  );

  hdfb_link_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) link_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .data_byte     (data_byte),
    .address       (address),
    .response_size (response_size),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .tx_enable     (tx_enable),
    .frame_ready   (frame_ready),
    .frame_length  (frame_length),
    .read_data     (read_data),
    .overflow      (overflow),
    .mode          (mode),
    .mismatch_count(mismatches),
    .pending       (pending),
    .link_mode_now (pred_mode),
    .fill_now      (pred_fill)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // Response back-pressure: a fresh coin per cycle, changed on the falling
  // edge so the block sees a settled value at the rising edge.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // One request transaction. Entered and left on a falling edge. Valid is
  // only dropped inside the optional idle gap, so a back-to-back transaction
  // keeps valid high without a second assignment in the same step.
  task automatic send_item(input logic [2:0] op, input logic [7:0] din,
                           input logic [6:0] addr, input logic [7:0] rsize);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid     <= 1'b1;
    req_type      <= op;
    data_byte     <= din;
    address       <= addr;
    response_size <= rsize;
    // payload holds until the block takes it
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender goes quiet until every outstanding response has come back, then
  // idles further so the pipeline is empty. Registers are only touched after this.
  task automatic settle();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LINK_LATENCY + 2) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] s, input logic [6:0] l,
                           input logic [7:0] t);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FRAME_MARKER;
    cfg_data  <= s;
    @(negedge clk);
    cfg_index <= CFG_LENGTH_INDEX;
    cfg_data  <= {1'b0, l};
    @(negedge clk);
    cfg_index <= CFG_TRAILER_BYTES;
    cfg_data  <= t;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    sentinel = s;
    len_idx  = l;
    trailer  = t;
  endtask

  // A request the block has to ignore in link mode m.
  function automatic logic [2:0] stray_op(input logic [2:0] m);
    logic [2:0] op;
    bit         ok;
    ok = 1'b0;
    op = REQ_UNUSED_6;
    while (!ok) begin
      op = 3'($urandom_range(7));
      case (op)
        REQ_RX_BYTE:                 ok = (m != MODE_LISTEN) && (m != MODE_RECV);
        REQ_BUF_READ, REQ_BUF_WRITE: ok = 1'b0;
        REQ_REPLY:                   ok = (m != MODE_HOLD);
        REQ_TX_SLOT:                 ok = (m != MODE_SEND);
        REQ_TX_DONE:                 ok = (m != MODE_DRAIN);
        default:                     ok = 1'b1;
      endcase
    end
    return op;
  endfunction

  // One random transaction, steered by the predicted link mode so that most
  // traffic walks full sessions: sentinel, header, length byte, payload and
  // trailer, software access, reply, slots, tx complete. The rest is buffer
  // access at odd moments and requests the current mode must ignore.
  // 'useful' is low for transactions the block is expected to ignore.
  task automatic random_item(output bit useful);
    logic [2:0] op;
    logic [7:0] din;
    logic [6:0] addr;
    logic [7:0] rsize;
    int         r;
    int         lim;
    din    = 8'($urandom);
    addr   = 7'($urandom);
    rsize  = 8'($urandom);
    r      = $urandom_range(99);
    useful = 1'b1;
    case (pred_mode)
      MODE_LISTEN: begin
        if (r < 60) begin
          op  = REQ_RX_BYTE;
          din = sentinel;
        end else if (r < 70) begin
          // line noise between frames; only a sentinel hit does anything
          op     = REQ_RX_BYTE;
          useful = (din == sentinel);
        end else if (r < 80) begin
          op = $urandom_range(1) ? REQ_BUF_READ : REQ_BUF_WRITE;
        end else begin
          op     = stray_op(pred_mode);
          useful = 1'b0;
        end
      end
      MODE_RECV: begin
        if (r < 85) begin
          op = REQ_RX_BYTE;
          if (pred_fill == len_idx) begin
            // Length byte: mostly a length that fits the buffer with the
            // trailer, now and then anything (overflow when it cannot fit).
            lim = BUFFER_DEPTH - 1 - int'(len_idx) - int'(trailer);
            if (lim >= 0 && $urandom_range(99) < 90)
              din = 8'($urandom_range((lim > 12) ? 12 : lim, 0));
          end
        end else if (r < 92) begin
          op = $urandom_range(1) ? REQ_BUF_READ : REQ_BUF_WRITE;
        end else begin
          op     = stray_op(pred_mode);
          useful = 1'b0;
        end
      end
      MODE_HOLD: begin
        if (r < 20) begin
          op = REQ_BUF_READ;
        end else if (r < 35) begin
          op = REQ_BUF_WRITE;
        end else if (r < 45) begin
          op     = stray_op(pred_mode);
          useful = 1'b0;
        end else begin
          // reply sizes: mostly short, some "no reply", a few clamped at depth
          op = REQ_REPLY;
          r  = $urandom_range(99);
          if (r < 8)       rsize = 8'd0;
          else if (r < 12) rsize = 8'($urandom_range(255, 100));
          else             rsize = 8'($urandom_range(8, 1));
        end
      end
      MODE_SEND: begin
        if (r < 80) begin
          op = REQ_TX_SLOT;
        end else if (r < 88) begin
          op = $urandom_range(1) ? REQ_BUF_READ : REQ_BUF_WRITE;
        end else begin
          op     = stray_op(pred_mode);
          useful = 1'b0;
        end
      end
      MODE_DRAIN: begin
        if (r < 75) begin
          op = REQ_TX_DONE;
        end else if (r < 85) begin
          op = $urandom_range(1) ? REQ_BUF_READ : REQ_BUF_WRITE;
        end else begin
          op     = stray_op(pred_mode);
          useful = 1'b0;
        end
      end
      default: begin
        op     = stray_op(pred_mode);
        useful = 1'b0;
      end
    endcase
    send_item(op, din, addr, rsize);
  endtask

  // Quiet, set the registers, pick the idle and stall patterns, then run random
  // sessions until 'quota' transactions the block acts on have gone in.
  task automatic run_phase(input logic [7:0] s, input logic [6:0] l,
                           input logic [7:0] t, input int ip, input int sp,
                           input int quota);
    int count;
    bit useful;
    settle();
    configure(s, l, t);
    idle_pct  = ip;
    stall_pct = sp;
    count     = 0;
    while (count < quota) begin
      random_item(useful);
      if (useful) count++;
    end
  endtask

  initial begin
    int a;
    // every input known from time zero
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_FRAME_MARKER;
    cfg_data      = 8'h00;
    req_valid     = 1'b0;
    req_type      = REQ_RX_BYTE;
    data_byte     = 8'h00;
    address       = 7'd0;
    response_size = 8'd0;
    idle_pct      = 0;
    stall_pct     = 0;
    sentinel      = 8'h00;
    len_idx       = 7'd1;
    trailer       = 8'd5;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The buffer has no reset value: write every entry first so that no read
    // and no reply ever touches an unwritten byte.
    for (a = 0; a < BUFFER_DEPTH; a++)
      send_item(REQ_BUF_WRITE, 8'($urandom), 7'(a), 8'($urandom));

    // ---- directed walk: sentinel A5, length at index 1, no trailer ----
    settle();
    configure(8'hA5, 7'd1, 8'd0);
    send_item(REQ_UNUSED_6,  8'h00, 7'd0,   8'd0);    // undefined codes
    send_item(REQ_UNUSED_7,  8'hFF, 7'd127, 8'd255);
    send_item(REQ_RX_BYTE,   8'h00, 7'd0,   8'd0);    // not a sentinel
    send_item(REQ_REPLY,     8'h00, 7'd0,   8'd5);    // wrong mode
    send_item(REQ_TX_SLOT,   8'h00, 7'd0,   8'd0);    // wrong mode
    send_item(REQ_TX_DONE,   8'h00, 7'd0,   8'd0);    // wrong mode
    send_item(REQ_RX_BYTE,   8'hA5, 7'd0,   8'd0);    // frame opens
    send_item(REQ_RX_BYTE,   8'hFF, 7'd0,   8'd0);
    send_item(REQ_RX_BYTE,   8'h00, 7'd0,   8'd0);    // zero count: done on length
    send_item(REQ_RX_BYTE,   8'hA5, 7'd0,   8'd0);    // ignored while holding
    send_item(REQ_BUF_READ,  8'h00, 7'd0,   8'd0);
    send_item(REQ_BUF_READ,  8'h00, 7'd127, 8'd0);
    send_item(REQ_BUF_WRITE, 8'h5A, 7'd127, 8'd0);
    send_item(REQ_BUF_WRITE, 8'h3C, 7'd2,   8'd0);
    send_item(REQ_REPLY,     8'h00, 7'd0,   8'd3);    // sentinel goes out
    send_item(REQ_TX_DONE,   8'h00, 7'd0,   8'd0);    // too early
    send_item(REQ_TX_SLOT,   8'h00, 7'd0,   8'd0);
    send_item(REQ_TX_SLOT,   8'h00, 7'd0,   8'd0);
    send_item(REQ_TX_SLOT,   8'h00, 7'd0,   8'd0);    // last byte, draining
    send_item(REQ_TX_SLOT,   8'h00, 7'd0,   8'd0);    // no slot while draining
    send_item(REQ_RX_BYTE,   8'hA5, 7'd0,   8'd0);    // ignored while draining
    send_item(REQ_TX_DONE,   8'h00, 7'd0,   8'd0);    // back to listening
    send_item(REQ_RX_BYTE,   8'hA5, 7'd0,   8'd0);
    send_item(REQ_RX_BYTE,   8'h01, 7'd0,   8'd0);
    send_item(REQ_RX_BYTE,   8'h01, 7'd0,   8'd0);    // length 1
    send_item(REQ_RX_BYTE,   8'h7E, 7'd0,   8'd0);    // completes
    send_item(REQ_REPLY,     8'h00, 7'd0,   8'd0);    // no reply, listen again

    // ---- random sessions: register extremes and all idle patterns ----
    //        sentinel length   trailer idle stall count
    run_phase(8'h00,   7'd1,   8'd5,   0,   0,    200);  // reset values
    run_phase(8'hFF,   7'd0,   8'd0,   67,  0,    200);
    run_phase(8'h3C,   7'd127, 8'd0,   0,   67,   200);  // frames fill the buffer
    run_phase(8'h5A,   7'd7,   8'd255, 17,  17,   120);  // every frame overflows
    run_phase(8'h81,   7'd3,   8'd2,   0,   0,    200);
    run_phase(8'h7F,   7'd2,   8'd4,   67,  0,    200);
    run_phase(8'hE7,   7'd10,  8'd1,   0,   67,   200);
    run_phase(8'h12,   7'd1,   8'd5,   17,  17,   180);

    // drain: no more stalls, wait for the last responses and a little beyond
    stall_pct = 0;
    settle();
    repeat (LINK_LATENCY + 4) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hdfb_pkg.sv
hw/rtl/hdfb_ram.sv
hw/rtl/hdfb_ctrl.sv
hw/rtl/half_duplex_frame_buffer_unit.sv
tb/hdfb_link_checker.sv
tb/tb_half_duplex_frame_buffer_unit.sv
